// ===== sv/vtc_pkg.sv =====
// Shared types and constants for the valve travel controller.
`timescale 1ns / 1ps

package vtc_pkg;

    localparam int CountW = 9;
    localparam int LimitW = 8;
    localparam int CfgIdxW = 1;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_OPEN   = 2'd1,
        KIND_CLOSE  = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        POS_OPEN   = 2'd0,
        POS_CLOSED = 2'd1,
        POS_MIDWAY = 2'd2
    } position_t;

    typedef enum logic [2:0] {
        OUT_NONE           = 3'd0,
        OUT_ALREADY_OPEN   = 3'd1,
        OUT_ALREADY_CLOSED = 3'd2,
        OUT_OPENED         = 3'd3,
        OUT_CLOSED         = 3'd4,
        OUT_TIMEOUT        = 3'd5,
        OUT_REJECTED       = 3'd6
    } outcome_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MAX_TRAVEL = 1'b0,
        CFG_USE_POWER  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic              moving;
        logic              target_open;
        logic [CountW-1:0] travel_count;
        logic              direction_relay;
        logic              supply_relay;
    } vtc_state_t;

    typedef struct packed {
        position_t position;
        outcome_t  outcome;
    } vtc_result_t;

endpackage

// ===== sv/vtc_step.sv =====
// Per-transaction decision logic: position decode, command and tick handling.
`timescale 1ns / 1ps

module vtc_step (
    input  vtc_pkg::vtc_state_t  state_cur,
    input  logic [1:0]           kind,
    input  logic                 open_switch,
    input  logic                 close_switch,
    input  logic [7:0]           max_travel_seconds,
    input  logic                 use_power_relay,
    output vtc_pkg::vtc_state_t  state_new,
    output vtc_pkg::vtc_result_t result
);
    import vtc_pkg::*;

    position_t pos;
    logic      want_open;

    // Open switch wins when both are low.
    always_comb begin
        if (!open_switch) begin
            pos = POS_OPEN;
        end else if (!close_switch) begin
            pos = POS_CLOSED;
        end else begin
            pos = POS_MIDWAY;
        end
    end

    assign want_open = (kind_t'(kind) == KIND_OPEN);

    always_comb begin
        state_new      = state_cur;
        result.position = pos;
        result.outcome  = OUT_NONE;
        case (kind_t'(kind))
            KIND_OPEN, KIND_CLOSE: begin
                if (state_cur.moving) begin
                    result.outcome = OUT_REJECTED;
                end else if (want_open && pos == POS_OPEN) begin
                    result.outcome = OUT_ALREADY_OPEN;
                end else if (!want_open && pos == POS_CLOSED) begin
                    result.outcome = OUT_ALREADY_CLOSED;
                end else begin
                    state_new.moving          = 1'b1;
                    state_new.target_open     = want_open;
                    state_new.travel_count    = '0;
                    state_new.direction_relay = want_open;
                    state_new.supply_relay    = use_power_relay;
                end
            end
            KIND_TICK: begin
                if (state_cur.moving) begin
                    if (state_cur.travel_count > {1'b0, max_travel_seconds}) begin
                        state_new.moving       = 1'b0;
                        state_new.supply_relay = 1'b0;
                        result.outcome         = OUT_TIMEOUT;
                    end else begin
                        state_new.travel_count = state_cur.travel_count + 9'd1;
                        if (state_cur.target_open && pos == POS_OPEN) begin
                            state_new.moving       = 1'b0;
                            state_new.supply_relay = 1'b0;
                            result.outcome         = OUT_OPENED;
                        end else if (!state_cur.target_open && pos == POS_CLOSED) begin
                            state_new.moving       = 1'b0;
                            state_new.supply_relay = 1'b0;
                            result.outcome         = OUT_CLOSED;
                        end
                    end
                end
            end
            default: begin
                // Status query: report only.
            end
        endcase
    end

endmodule

// ===== sv/valve_travel_controller_core.sv =====
// Top level of the valve travel controller: input register, decision step, result register.
`timescale 1ns / 1ps
// A transaction passes through the input register and then the result register.
// One transaction per cycle while the sink is ready; the controller state updates in the same
//   cycle a transaction moves from the input register into the result register.
// Reset (aresetn low, synchronous): both stages empty, valve idle, relays off,
//   max_travel_seconds = 8, use_power_relay = 0.
// Both stages keep accepting while the result waits, so ready drops only when both are full.

module valve_travel_controller_core (
    input  logic       aclk,
    input  logic       aresetn,

    // Configuration write port
    input  logic       cfg_we,
    input  logic [vtc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [7:0] cfg_wdata,

    // Input transactions
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic       s_open_switch,
    input  logic       s_close_switch,

    // Result transactions
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_position,
    output logic       m_valve_drive,
    output logic       m_power_drive,
    output logic       m_busy_res,
    output logic [2:0] m_outcome
);
    import vtc_pkg::*;

    // Configuration registers
    logic [LimitW-1:0] max_travel_reg;
    logic              use_power_reg;

    // Input stage
    logic       in_vld_reg;
    logic [1:0] in_kind_reg;
    logic       in_open_reg;
    logic       in_close_reg;

    // Controller state
    vtc_state_t state_reg;
    vtc_state_t state_next;

    // Result stage
    logic        out_vld_reg;
    vtc_result_t step_result;
    logic [1:0]  out_pos_reg;
    logic        out_valve_reg;
    logic        out_power_reg;
    logic        out_busy_reg;
    logic [2:0]  out_outcome_reg;

    logic advance;
    logic in_take;

    // The input register hands over when the result register is empty or being drained.
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign in_take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_travel_reg <= 8'd8;
            use_power_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_MAX_TRAVEL: max_travel_reg <= cfg_wdata;
                CFG_USE_POWER:  use_power_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_take) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_kind_reg  <= s_kind;
            in_open_reg  <= s_open_switch;
            in_close_reg <= s_close_switch;
        end
    end

    vtc_step u_step (
        .state_cur          (state_reg),
        .kind               (in_kind_reg),
        .open_switch        (in_open_reg),
        .close_switch       (in_close_reg),
        .max_travel_seconds (max_travel_reg),
        .use_power_relay    (use_power_reg),
        .state_new          (state_next),
        .result             (step_result)
    );

    // State commits exactly once per transaction, when it enters the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_pos_reg     <= step_result.position;
            out_valve_reg   <= state_next.direction_relay;
            out_power_reg   <= state_next.supply_relay;
            out_busy_reg    <= state_next.moving;
            out_outcome_reg <= step_result.outcome;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_position    = out_pos_reg;
    assign m_valve_drive = out_valve_reg;
    assign m_power_drive = out_power_reg;
    assign m_busy_res    = out_busy_reg;
    assign m_outcome     = out_outcome_reg;

    // Supply relay is never on outside a move.
    a_power_only_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.supply_relay |-> state_reg.moving)
        else $error("supply relay on while idle");

    // Count can never pass one beyond the largest limit.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.travel_count <= 9'd256)
        else $error("travel count out of range");

    // A rejected command is only reported while a move is still running.
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_outcome == OUT_REJECTED) |-> m_busy_res)
        else $error("rejection reported while idle");

    // A finished or timed-out move reports idle with the supply relay off.
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_outcome == OUT_TIMEOUT || m_outcome == OUT_OPENED
            || m_outcome == OUT_CLOSED)) |-> (!m_busy_res && !m_power_drive))
        else $error("move end left the valve busy or powered");

    // Input stalls only when both stages are full and the sink holds off.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && out_vld_reg && !m_ready))
        else $error("input stalled without a full pipeline");

endmodule
